### hw/rtl/dtw_pkg.sv
`default_nettype none

package dtw_pkg;

    // Field widths of the request and the result.
    localparam int FREQ_W   = 16;
    localparam int BAND_W   = 8;
    localparam int SW_W     = 3;
    localparam int DIVC_W   = 8;
    localparam int TW_W     = 48;

    // Internal widths: t below 2^23, N below 2^7, 280000*N below 2^25.
    localparam int T_W      = 23;
    localparam int N_W      = 7;
    localparam int DEN_W    = 25;
    localparam int REM_W    = DEN_W + 1;

    // Default tuning word width and quotient bits per divider stage.
    localparam int WORD_BITS_DEF = 48;
    localparam int DIV_STEPS     = 4;

    localparam logic [BAND_W-1:0] BAND_MASK  = 8'hC3;
    localparam logic [BAND_W-1:0] BAND_MATCH = 8'h80;
    localparam logic [T_W-1:0]    LOW_LIMIT  = 23'd960000;
    localparam logic [T_W-1:0]    MID_LIMIT  = 23'd1100000;
    localparam logic [T_W-1:0]    LOW_OFFSET = 23'd1600000;
    localparam logic [T_W-1:0]    HIGH_OFFSET = 23'd800000;
    localparam logic [T_W-1:0]    DIV_STEP   = 23'd76000;
    localparam logic [N_W-1:0]    EVEN_ABOVE = 7'd38;
    localparam logic [18:0]       DDS_SCALE  = 19'd280000;
    localparam logic [6:0]        FREQ_SCALE = 7'd100;
    // Reciprocal of the divider step, floor(2^32 / 76000).
    localparam logic [15:0]       STEP_RECIP = 16'd56512;
    localparam int                RECIP_SHIFT = 32;

    // Range switch codes.
    localparam logic [SW_W-1:0] SW_LOW  = 3'd1;
    localparam logic [SW_W-1:0] SW_MID  = 3'd2;
    localparam logic [SW_W-1:0] SW_HIGH = 3'd4;

    localparam logic [DIVC_W-1:0] N_BIAS = 8'd4;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_request;
        logic [BAND_W-1:0] band_byte;
    } req_t;

    typedef struct packed {
        logic [SW_W-1:0]   switch_code;
        logic [DIVC_W-1:0] divider_code;
        logic [TW_W-1:0]   tuning_word;
    } rsp_t;

    // Fields that ride along the divider chain unchanged.
    typedef struct packed {
        logic [SW_W-1:0]   switch_code;
        logic [DIVC_W-1:0] divider_code;
    } side_t;

endpackage

`default_nettype wire

### hw/rtl/dtw_front.sv
`default_nettype none

module dtw_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             req_valid,
    input  wire dtw_pkg::req_t    req,
    output logic                  valid,
    output logic [dtw_pkg::T_W-1:0]   t,
    output logic [dtw_pkg::DEN_W-1:0] den,
    output dtw_pkg::side_t        side
);

    logic [3:0] v_reg, v_next;

    logic [dtw_pkg::T_W-1:0]  t1_reg, t1_next, t2_reg, t3_reg, t4_reg;
    logic [dtw_pkg::SW_W-1:0] sw1_reg, sw1_next, sw2_reg, sw3_reg, sw4_reg;
    logic [dtw_pkg::N_W-1:0]  n2_reg, n2_next, n3_reg, n3_next;
    logic [dtw_pkg::DEN_W-1:0] den4_reg, den4_next;
    logic [dtw_pkg::DIVC_W-1:0] dc4_reg, dc4_next;

    logic                     hit;
    logic [dtw_pkg::T_W-1:0]  s;
    logic [38:0]              prod;
    logic [dtw_pkg::T_W-1:0]  rem;
    logic [dtw_pkg::N_W-1:0]  n_fix;
    logic [31:0]              den_full;

    // Stage 1: band check, scaling and range selection.
    always_comb
    begin
        hit = (req.band_byte & dtw_pkg::BAND_MASK) == dtw_pkg::BAND_MATCH;
        s   = dtw_pkg::T_W'(req.freq_request * dtw_pkg::FREQ_SCALE);
        if (s <= dtw_pkg::LOW_LIMIT)
        begin
            t1_next  = s + dtw_pkg::LOW_OFFSET;
            sw1_next = dtw_pkg::SW_LOW;
        end
        else if (s <= dtw_pkg::MID_LIMIT)
        begin
            t1_next  = s + dtw_pkg::HIGH_OFFSET;
            sw1_next = dtw_pkg::SW_MID;
        end
        else
        begin
            t1_next  = s + dtw_pkg::HIGH_OFFSET;
            sw1_next = dtw_pkg::SW_HIGH;
        end
    end

    // Stage 2: divider estimate by reciprocal multiplication, low by at most one.
    always_comb
    begin
        prod    = 39'(t1_reg) * 39'(dtw_pkg::STEP_RECIP);
        n2_next = prod[38:dtw_pkg::RECIP_SHIFT];
    end

    // Stage 3: correct the estimate, then force it even above the limit.
    always_comb
    begin
        rem   = t2_reg - dtw_pkg::T_W'(n2_reg * dtw_pkg::DIV_STEP);
        n_fix = (rem >= dtw_pkg::DIV_STEP) ? n2_reg + 7'd1 : n2_reg;
        if (n_fix > dtw_pkg::EVEN_ABOVE)
        begin
            n3_next = {n_fix[dtw_pkg::N_W-1:1], 1'b0};
        end
        else
        begin
            n3_next = n_fix;
        end
    end

    // Stage 4: divisor 280000*N and the emitted divider code.
    always_comb
    begin
        den_full  = 32'(n3_reg) * 32'(dtw_pkg::DDS_SCALE);
        den4_next = den_full[dtw_pkg::DEN_W-1:0];
        dc4_next  = dtw_pkg::DIVC_W'(n3_reg) - dtw_pkg::N_BIAS;
    end

    assign v_next = {v_reg[2:0], req_valid & hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= t1_next;
            sw1_reg  <= sw1_next;
            t2_reg   <= t1_reg;
            sw2_reg  <= sw1_reg;
            n2_reg   <= n2_next;
            t3_reg   <= t2_reg;
            sw3_reg  <= sw2_reg;
            n3_reg   <= n3_next;
            t4_reg   <= t3_reg;
            sw4_reg  <= sw3_reg;
            den4_reg <= den4_next;
            dc4_reg  <= dc4_next;
        end
    end

    assign valid             = v_reg[3];
    assign t                 = t4_reg;
    assign den               = den4_reg;
    assign side.switch_code  = sw4_reg;
    assign side.divider_code = dc4_reg;

endmodule

`default_nettype wire

### hw/rtl/dtw_div_stage.sv
`default_nettype none

module dtw_div_stage #(
    parameter int WORD_BITS = dtw_pkg::WORD_BITS_DEF,
    parameter int STEPS     = dtw_pkg::DIV_STEPS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [dtw_pkg::REM_W-1:0]   in_rem,
    input  wire logic [dtw_pkg::DEN_W-1:0]   in_den,
    input  wire logic [WORD_BITS-1:0]        in_quo,
    input  wire dtw_pkg::side_t              in_side,
    output logic                             out_valid,
    output logic [dtw_pkg::REM_W-1:0]        out_rem,
    output logic [dtw_pkg::DEN_W-1:0]        out_den,
    output logic [WORD_BITS-1:0]             out_quo,
    output dtw_pkg::side_t                   out_side
);

    logic                      valid_reg;
    logic [dtw_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [dtw_pkg::DEN_W-1:0] den_reg;
    logic [WORD_BITS-1:0]      quo_reg, quo_next;
    dtw_pkg::side_t            side_reg;

    // STEPS restoring division steps: shift in a zero, subtract when it fits.
    always_comb
    begin
        logic [dtw_pkg::REM_W-1:0] r;
        logic [WORD_BITS-1:0]      q;
        logic                      fit;
        r = in_rem;
        q = in_quo;
        for (int i = 0; i < STEPS; i++)
        begin
            r   = {r[dtw_pkg::REM_W-2:0], 1'b0};
            fit = r >= {1'b0, in_den};
            if (fit)
            begin
                r = r - {1'b0, in_den};
            end
            q = {q[WORD_BITS-2:0], fit};
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hw/rtl/pll_dds_tuning_word_calc_core.sv
// Synthesizer retune calculator: PLL divider code, range switch and DDS tuning word.
// The request channel (req_valid, req_stall, req) carries a frequency request and
// a band byte. Only requests whose band byte matches the selected band give a
// result; others are taken and dropped without any response transaction.
// The response channel (rsp_valid, rsp_stall, rsp) carries the switch code,
// the divider code N-4 and the tuning word floor(2^WORD_BITS*t/(280000*N)).
// Throughput is one request per cycle while no stalled response is held. Four front
// stages compute t and N, then a chain of divider stages produces four quotient
// bits each (the last stage may produce fewer).
// The whole pipeline moves as one: while a response is shown and stalled, every
// stage holds and req_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits; the block is ready for requests right after it.
`default_nettype none

module pll_dds_tuning_word_calc_core #(
    parameter int WORD_BITS = dtw_pkg::WORD_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire dtw_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dtw_pkg::rsp_t      rsp
);

    localparam int NSTAGE = (WORD_BITS + dtw_pkg::DIV_STEPS - 1) / dtw_pkg::DIV_STEPS;

    logic                      en;
    logic                      f_valid;
    logic [dtw_pkg::T_W-1:0]   f_t;
    logic [dtw_pkg::DEN_W-1:0] f_den;
    dtw_pkg::side_t            f_side;

    logic                      c_valid [NSTAGE+1];
    logic [dtw_pkg::REM_W-1:0] c_rem   [NSTAGE+1];
    logic [dtw_pkg::DEN_W-1:0] c_den   [NSTAGE+1];
    logic [WORD_BITS-1:0]      c_quo   [NSTAGE+1];
    dtw_pkg::side_t            c_side  [NSTAGE+1];

    // The pipeline advances unless a finished transaction is held at the output.
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    dtw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .valid     (f_valid),
        .t         (f_t),
        .den       (f_den),
        .side      (f_side)
    );

    // t is always below the divisor, so the integer quotient is zero.
    assign c_valid[0] = f_valid;
    assign c_rem[0]   = dtw_pkg::REM_W'(f_t);
    assign c_den[0]   = f_den;
    assign c_quo[0]   = '0;
    assign c_side[0]  = f_side;

    // Divider chain; the last stage may take fewer steps.
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_div
        localparam int LEFT = WORD_BITS - k * dtw_pkg::DIV_STEPS;
        localparam int CNT  = (LEFT < dtw_pkg::DIV_STEPS) ? LEFT : dtw_pkg::DIV_STEPS;

        dtw_div_stage #(
            .WORD_BITS (WORD_BITS),
            .STEPS     (CNT)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[k]),
            .in_rem    (c_rem[k]),
            .in_den    (c_den[k]),
            .in_quo    (c_quo[k]),
            .in_side   (c_side[k]),
            .out_valid (c_valid[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_den   (c_den[k+1]),
            .out_quo   (c_quo[k+1]),
            .out_side  (c_side[k+1])
        );
    end

    assign rsp_valid        = c_valid[NSTAGE];
    assign rsp.switch_code  = c_side[NSTAGE].switch_code;
    assign rsp.divider_code = c_side[NSTAGE].divider_code;
    assign rsp.tuning_word  = dtw_pkg::TW_W'(c_quo[NSTAGE]);

endmodule

`default_nettype wire

### hw/rtl/dtw_checker.sv
`default_nettype none

module dtw_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire dtw_pkg::rsp_t rsp
);

    // A stalled response transaction stays in place.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // The request side stalls only behind a held response.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a held response");

    // Exactly one range switch bit is set.
    a_switch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot(rsp.switch_code))
        else $error("bad switch code");

    // N lies in 21..96, so the divider code lies in 17..92.
    a_divider: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.divider_code >= 8'd17 && rsp.divider_code <= 8'd92)
        else $error("divider code out of range");

    // The tuning word stays below half of full scale.
    a_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !rsp.tuning_word[dtw_pkg::TW_W-1])
        else $error("tuning word top bit set");

endmodule

bind pll_dds_tuning_word_calc_core dtw_checker u_dtw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;

    typedef enum logic {ROW_DROP, ROW_CALC} row_kind_e;

    typedef struct packed {
        row_kind_e                  kind;
        logic [dtw_pkg::FREQ_W-1:0] freq;
        logic [dtw_pkg::BAND_W-1:0] band;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    dtw_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    dtw_pkg::rsp_t rsp;

    dtw_pkg::rsp_t settings_q[$];
    int            error_count;
    int            hold_cycles;
    bit            quiet_mode;

    pll_dds_tuning_word_calc_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Compute the synthesizer settings for one request; returns 0 when the band is not selected.
    function automatic bit calc_settings(input dtw_pkg::req_t r, output dtw_pkg::rsp_t s);
        logic [dtw_pkg::T_W-1:0]   scaled;
        logic [dtw_pkg::T_W-1:0]   synth;
        logic [dtw_pkg::N_W-1:0]   div_n;
        logic [dtw_pkg::DEN_W-1:0] den;
        logic [79:0]               num;
        logic [79:0]               quo;
        s = '0;
        if ((r.band_byte & dtw_pkg::BAND_MASK) != dtw_pkg::BAND_MATCH)
            return 0;
        scaled = dtw_pkg::T_W'(r.freq_request) * dtw_pkg::T_W'(dtw_pkg::FREQ_SCALE);
        if (scaled <= dtw_pkg::LOW_LIMIT)
        begin
            synth = scaled + dtw_pkg::LOW_OFFSET;
            s.switch_code = dtw_pkg::SW_LOW;
        end
        else
        begin
            synth = scaled + dtw_pkg::HIGH_OFFSET;
            s.switch_code = (scaled <= dtw_pkg::MID_LIMIT) ? dtw_pkg::SW_MID : dtw_pkg::SW_HIGH;
        end
        div_n = dtw_pkg::N_W'(synth / dtw_pkg::DIV_STEP);
        if (div_n > dtw_pkg::EVEN_ABOVE)
            div_n[0] = 1'b0;
        den = dtw_pkg::DEN_W'(dtw_pkg::DDS_SCALE) * dtw_pkg::DEN_W'(div_n);
        num = 80'(synth) << dtw_pkg::TW_W;
        quo = num / 80'(den);
        s.divider_code = dtw_pkg::DIVC_W'(div_n) - dtw_pkg::N_BIAS;
        s.tuning_word = quo[dtw_pkg::TW_W-1:0];
        return 1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Offer one transaction and wait until it is taken, then record its expected settings if it should give a response.
    task automatic send_request(input dtw_pkg::req_t r, input bit drop_only);
        dtw_pkg::rsp_t s;
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (calc_settings(r, s) && !drop_only)
            settings_q.push_back(s);
        // Idle cycles come one at a time, each with the same chance.
        while (!quiet_mode && $urandom_range(0, 99) < 26)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Response stall: long hold-offs, quiet stretches, random stalls otherwise.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else if (quiet_mode)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 26);
        end
    end

    // Check each response transaction against the oldest expectation.
    always @(posedge clk)
    begin
        dtw_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (settings_q.size() == 0)
                report_mismatch("response with nothing expected");
            else
            begin
                want = settings_q.pop_front();
                if (rsp.switch_code !== want.switch_code)
                    report_mismatch($sformatf("switch_code %0d, expected %0d",
                                              rsp.switch_code, want.switch_code));
                if (rsp.divider_code !== want.divider_code)
                    report_mismatch($sformatf("divider_code %0d, expected %0d",
                                              rsp.divider_code, want.divider_code));
                if (rsp.tuning_word !== want.tuning_word)
                    report_mismatch($sformatf("tuning_word %h, expected %h",
                                              rsp.tuning_word, want.tuning_word));
            end
        end
    end

    // Hard limit on run time.
    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus.
    initial
    begin
        stim_row_t     rows[$];
        dtw_pkg::req_t r;
        int            pick;
        rows = '{
            '{ROW_CALC, 16'd0,     8'h80},
            '{ROW_CALC, 16'd65535, 8'h80},
            '{ROW_CALC, 16'd9600,  8'h80},
            '{ROW_CALC, 16'd9601,  8'h80},
            '{ROW_CALC, 16'd11000, 8'h80},
            '{ROW_CALC, 16'd11001, 8'h80},
            '{ROW_CALC, 16'd20880, 8'h80},
            '{ROW_CALC, 16'd22000, 8'h80},
            '{ROW_CALC, 16'd22001, 8'hBC},
            '{ROW_CALC, 16'hAAAA,  8'hA4},
            '{ROW_CALC, 16'h5555,  8'h98},
            '{ROW_DROP, 16'd5000,  8'h00},
            '{ROW_DROP, 16'd5000,  8'hFF},
            '{ROW_DROP, 16'd5000,  8'h81},
            '{ROW_DROP, 16'd5000,  8'h82},
            '{ROW_DROP, 16'd5000,  8'h40},
            '{ROW_DROP, 16'd5000,  8'hC0},
            '{ROW_DROP, 16'd65535, 8'h7F}
        };
        error_count = 0;
        hold_cycles = 0;
        quiet_mode = 1'b1;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; dropped rows must give no response.
        foreach (rows[i])
        begin
            r.freq_request = rows[i].freq;
            r.band_byte = rows[i].band;
            send_request(r, rows[i].kind == ROW_DROP);
        end

        // Random part: a quiet stretch first, then random idling on both sides, a long hold-off and a drain.
        for (int k = 0; k < 1800; k++)
        begin
            if (k == 300)
                quiet_mode = 1'b0;
            if (k == 600)
                hold_cycles = 150;
            if (k == 1000)
            begin
                req_valid <= 1'b0;
                while (settings_q.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.freq_request = dtw_pkg::FREQ_W'($urandom_range(0, 65535));
            else if (pick < 80)
                r.freq_request = dtw_pkg::FREQ_W'($urandom_range(0, 12000));
            else
                r.freq_request = dtw_pkg::FREQ_W'($urandom_range(20000, 23000));
            if ($urandom_range(0, 99) < 85)
                r.band_byte = dtw_pkg::BAND_MATCH
                              | (dtw_pkg::BAND_W'($urandom) & ~dtw_pkg::BAND_MASK);
            else
                r.band_byte = dtw_pkg::BAND_W'($urandom_range(0, 255));
            send_request(r, 1'b0);
        end
        req_valid <= 1'b0;

        while (settings_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/dtw_pkg.sv
hw/rtl/dtw_front.sv
hw/rtl/dtw_div_stage.sv
hw/rtl/pll_dds_tuning_word_calc_core.sv
hw/rtl/dtw_checker.sv
sim/tb_top.sv
